// ----- hdl/banked_register_mode_switch_core_macros.svh -----
// Concurrent assertion helpers for the RTL.
`ifndef BANKED_REGISTER_MODE_SWITCH_CORE_MACROS_SVH
`define BANKED_REGISTER_MODE_SWITCH_CORE_MACROS_SVH

// Same-cycle implication.
`define BRMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/brms_pkg.sv -----
`timescale 1ns / 1ps

package brms_pkg;

  localparam int unsigned NumGpr   = 16;
  localparam int unsigned NumBanks = 6;
  localparam int unsigned NumFiqRegs = 5;

  localparam int unsigned RegSp = 13;
  localparam int unsigned RegLr = 14;
  localparam int unsigned RegPc = 15;
  localparam int unsigned FiqFirst = 8;

  localparam int unsigned BitT = 5;
  localparam int unsigned BitI = 7;

  localparam logic [4:0] ModeUsr = 5'h10;
  localparam logic [4:0] ModeFiq = 5'h11;
  localparam logic [4:0] ModeIrq = 5'h12;
  localparam logic [4:0] ModeSvc = 5'h13;
  localparam logic [4:0] ModeAbt = 5'h17;
  localparam logic [4:0] ModeUnd = 5'h1B;
  localparam logic [4:0] ModeSys = 5'h1F;

  localparam logic [2:0] BankUsr = 3'd0;
  localparam logic [2:0] BankFiq = 3'd1;
  localparam logic [2:0] BankIrq = 3'd2;
  localparam logic [2:0] BankSvc = 3'd3;
  localparam logic [2:0] BankAbt = 3'd4;
  localparam logic [2:0] BankUnd = 3'd5;

  localparam logic [31:0] VecIrq = 32'h0000_0018;
  localparam logic [31:0] VecSwi = 32'h0000_0008;

  localparam logic [31:0] CpsrReset = {27'd0, ModeSys};

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_MODE  = 3'd2,
    CMD_CPSR  = 3'd3,
    CMD_SPSR  = 3'd4,
    CMD_IRQ   = 3'd5,
    CMD_SWI   = 3'd6
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  new_mode;
  } req_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] saved_status;
    logic [31:0] status;
    logic [31:0] read_data;
    logic        irq_taken;
  } res_t;

  function automatic logic [2:0] bank_of(logic [4:0] mode);
    logic [2:0] bank;
    unique case (mode)
      ModeFiq: bank = BankFiq;
      ModeIrq: bank = BankIrq;
      ModeSvc: bank = BankSvc;
      ModeAbt: bank = BankAbt;
      ModeUnd: bank = BankUnd;
      default: bank = BankUsr;
    endcase
    return bank;
  endfunction

endpackage

// ----- hdl/brms_regfile.sv -----
`timescale 1ns / 1ps

module brms_regfile (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  brms_pkg::req_t   req_i,
  output brms_pkg::res_t   res_o
);

  logic [31:0] gpr_q [brms_pkg::NumGpr];
  logic [31:0] gpr_d [brms_pkg::NumGpr];
  logic [31:0] bank_sp_q [brms_pkg::NumBanks];
  logic [31:0] bank_sp_d [brms_pkg::NumBanks];
  logic [31:0] bank_lr_q [brms_pkg::NumBanks];
  logic [31:0] bank_lr_d [brms_pkg::NumBanks];
  logic [31:0] bank_spsr_q [brms_pkg::NumBanks];
  logic [31:0] bank_spsr_d [brms_pkg::NumBanks];
  logic [31:0] fiq_q [2][brms_pkg::NumFiqRegs];
  logic [31:0] fiq_d [2][brms_pkg::NumFiqRegs];
  logic [31:0] cpsr_q, cpsr_d;
  logic [31:0] spsr_q, spsr_d;

  logic        sw_en;
  logic [4:0]  sw_mode;
  logic [4:0]  cur_mode;
  logic [2:0]  old_bank;
  logic [2:0]  new_bank;
  logic        of_sel;
  logic        nf_sel;
  logic        exc;
  logic [31:0] exc_vec;
  logic [31:0] exc_extra;
  logic [31:0] exc_width;
  logic [31:0] read_data;
  logic        taken;

  assign cur_mode = cpsr_q[4:0];
  assign old_bank = brms_pkg::bank_of(cur_mode);
  assign new_bank = brms_pkg::bank_of(sw_mode);
  assign of_sel   = (old_bank == brms_pkg::BankFiq);
  assign nf_sel   = (new_bank == brms_pkg::BankFiq);
  assign exc_width = cpsr_q[brms_pkg::BitT] ? 32'd2 : 32'd4;

  always_comb begin
    gpr_d       = gpr_q;
    bank_sp_d   = bank_sp_q;
    bank_lr_d   = bank_lr_q;
    bank_spsr_d = bank_spsr_q;
    fiq_d       = fiq_q;
    cpsr_d      = cpsr_q;
    spsr_d      = spsr_q;
    sw_en       = 1'b0;
    sw_mode     = req_i.new_mode;
    exc         = 1'b0;
    exc_vec     = brms_pkg::VecSwi;
    exc_extra   = 32'd0;
    read_data   = '0;
    taken       = 1'b0;

    unique case (req_i.cmd)
      brms_pkg::CMD_READ: begin
        read_data = gpr_q[req_i.reg_index];
      end
      brms_pkg::CMD_WRITE: begin
        gpr_d[req_i.reg_index] = req_i.write_data;
      end
      brms_pkg::CMD_MODE: begin
        sw_en = 1'b1;
      end
      brms_pkg::CMD_CPSR: begin
        sw_en   = 1'b1;
        sw_mode = req_i.write_data[4:0];
      end
      brms_pkg::CMD_SPSR: begin
        spsr_d = req_i.write_data;
      end
      brms_pkg::CMD_IRQ: begin
        if (!cpsr_q[brms_pkg::BitI]) begin
          sw_en     = 1'b1;
          sw_mode   = brms_pkg::ModeIrq;
          exc       = 1'b1;
          exc_vec   = brms_pkg::VecIrq;
          exc_extra = 32'd4;
          taken     = 1'b1;
        end
      end
      brms_pkg::CMD_SWI: begin
        sw_en   = 1'b1;
        sw_mode = brms_pkg::ModeSvc;
        exc     = 1'b1;
      end
      default: begin
      end
    endcase

    // swap banked copies when a real mode change moves to another bank
    if (sw_en && (sw_mode != cur_mode)) begin
      if (old_bank != new_bank) begin
        if ((sw_mode == brms_pkg::ModeFiq) || (cur_mode == brms_pkg::ModeFiq)) begin
          for (int k = 0; k < brms_pkg::NumFiqRegs; k++) begin
            fiq_d[of_sel][k] = gpr_q[brms_pkg::FiqFirst + k];
            gpr_d[brms_pkg::FiqFirst + k] = fiq_q[nf_sel][k];
          end
        end
        bank_sp_d[old_bank]   = gpr_q[brms_pkg::RegSp];
        bank_lr_d[old_bank]   = gpr_q[brms_pkg::RegLr];
        bank_spsr_d[old_bank] = spsr_q;
        gpr_d[brms_pkg::RegSp] = bank_sp_q[new_bank];
        gpr_d[brms_pkg::RegLr] = bank_lr_q[new_bank];
        spsr_d = bank_spsr_q[new_bank];
      end
      cpsr_d[4:0] = sw_mode;
    end

    if (req_i.cmd == brms_pkg::CMD_CPSR) begin
      cpsr_d = req_i.write_data;
    end

    if (exc) begin
      gpr_d[brms_pkg::RegLr] = gpr_q[brms_pkg::RegPc] - exc_width + exc_extra;
      gpr_d[brms_pkg::RegPc] = exc_vec;
      spsr_d = cpsr_q;
      cpsr_d[brms_pkg::BitT] = 1'b0;
      cpsr_d[brms_pkg::BitI] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < brms_pkg::NumGpr; i++) begin
        gpr_q[i] <= '0;
      end
      for (int b = 0; b < brms_pkg::NumBanks; b++) begin
        bank_sp_q[b]   <= '0;
        bank_lr_q[b]   <= '0;
        bank_spsr_q[b] <= '0;
      end
      for (int f = 0; f < 2; f++) begin
        for (int k = 0; k < brms_pkg::NumFiqRegs; k++) begin
          fiq_q[f][k] <= '0;
        end
      end
      cpsr_q <= brms_pkg::CpsrReset;
      spsr_q <= '0;
    end else if (step_i) begin
      gpr_q       <= gpr_d;
      bank_sp_q   <= bank_sp_d;
      bank_lr_q   <= bank_lr_d;
      bank_spsr_q <= bank_spsr_d;
      fiq_q       <= fiq_d;
      cpsr_q      <= cpsr_d;
      spsr_q      <= spsr_d;
    end
  end

  assign res_o.read_data    = read_data;
  assign res_o.status       = cpsr_d;
  assign res_o.saved_status = spsr_d;
  assign res_o.pc           = gpr_d[brms_pkg::RegPc];
  assign res_o.irq_taken    = taken;

endmodule

// ----- hdl/banked_register_mode_switch_core.sv -----
`timescale 1ns / 1ps
// ARMv4T-style register file with banked SP, LR, SPSR and FIQ r8-r12 copies and
// IRQ/SWI exception entry. Unless the output stalls, one request is taken per
// clock: it is captured in an input register, applied to the register banks in a
// single pass of next-state logic, and its result (read data, CPSR, SPSR, PC,
// IRQ-taken flag) lands in an output register when the request advances.
// Without stalls it sustains one request per cycle, set by the single-pass update;
// the output register lets a new request enter while an earlier result waits.
`include "banked_register_mode_switch_core_macros.svh"

module banked_register_mode_switch_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] reg_index, [35:4] write_data, [40:36] new_mode, [47:41] zero
  input  logic [47:0]  s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] read_data, [63:32] status_out, [95:64] saved_status_out, [127:96] pc_out
  output logic [127:0] m_axis_tdata,
  // [0] irq_taken
  output logic         m_axis_tuser
);

  logic           in_valid_q, in_valid_d;
  brms_pkg::req_t req_q;
  logic           out_valid_q, out_valid_d;
  brms_pkg::res_t out_res_q;
  brms_pkg::res_t res;
  logic           s_fire;
  logic           advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_q.cmd        <= brms_pkg::cmd_e'(s_axis_tuser);
      req_q.reg_index  <= s_axis_tdata[3:0];
      req_q.write_data <= s_axis_tdata[35:4];
      req_q.new_mode   <= s_axis_tdata[40:36];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  brms_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (req_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.pc, out_res_q.saved_status,
                          out_res_q.status, out_res_q.read_data};
  assign m_axis_tuser  = out_res_q.irq_taken;

  `BRMS_ASSERT_NOW(a_irq_entry, clk_i, rst_ni,
    out_valid_q && out_res_q.irq_taken,
    out_res_q.status[brms_pkg::BitI] && !out_res_q.status[brms_pkg::BitT] &&
    (out_res_q.pc == brms_pkg::VecIrq) && (out_res_q.status[4:0] == brms_pkg::ModeIrq),
    "irq entry state wrong")
  `BRMS_ASSERT_NOW(a_irq_unmasked, clk_i, rst_ni,
    out_valid_q && out_res_q.irq_taken,
    !out_res_q.saved_status[brms_pkg::BitI], "irq taken while masked")
  `BRMS_ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, in_valid_q && !advance,
    in_valid_q && $stable(req_q), "request lost while stalled")

endmodule
